// ===== rtl/cht_pkg.sv =====
// Shared types and constants of the context handle table.
// Used by every module of the block; depends on nothing.
package cht_pkg;

	localparam logic [2:0] CMD_ALLOC      = 3'd0;
	localparam logic [2:0] CMD_FREE       = 3'd1;
	localparam logic [2:0] CMD_QUERY      = 3'd2;
	localparam logic [2:0] CMD_GET_PSTATE = 3'd3;
	localparam logic [2:0] CMD_SET_PSTATE = 3'd4;
	localparam logic [2:0] CMD_NOTE_HANG  = 3'd5;

	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_FULL    = 2'd1;
	localparam logic [1:0] STATUS_INVALID = 2'd2;
	localparam logic [1:0] STATUS_NOPERM  = 2'd3;

	localparam int CMD_W     = 3;
	localparam int HANDLE_W  = 7;
	localparam int STATUS_W  = 2;
	localparam int HANGS_W   = 32;
	localparam int SLOT_W    = 8;
	localparam int GRP_SIZE  = 16;
	localparam int GRP_IDX_W = 4;

	typedef enum logic [2:0] {
		OP_ALLOC,
		OP_FREE,
		OP_QUERY,
		OP_GET_PSTATE,
		OP_SET_PSTATE,
		OP_NOTE_HANG,
		OP_BAD
	} op_t;

	typedef struct packed {
		op_t               op;
		logic              in_range;
		logic [SLOT_W-1:0] slot;
	} item_t;

	typedef enum logic [2:0] {
		BK_IDLE = 3'b001,
		BK_READ = 3'b010,
		BK_EXEC = 3'b100
	} bk_state_t;

endpackage

// ===== rtl/cht_front.sv =====
// Front end: decodes an accepted item and checks its handle range.
// Depends on cht_pkg.
module cht_front #(
	parameter int NUM_CONTEXTS = 64
) (
	input  logic [cht_pkg::CMD_W-1:0]    command,
	input  logic [cht_pkg::HANDLE_W-1:0] context_handle,
	output cht_pkg::item_t               item
);

	logic [cht_pkg::SLOT_W:0] handle_x;

	always_comb begin
		handle_x = (cht_pkg::SLOT_W + 1)'(context_handle);
		item.in_range = (context_handle != '0) &&
			(handle_x <= (cht_pkg::SLOT_W + 1)'(NUM_CONTEXTS));
		item.slot = cht_pkg::SLOT_W'(handle_x - (cht_pkg::SLOT_W + 1)'(1));
		unique case (command)
			cht_pkg::CMD_ALLOC:      item.op = cht_pkg::OP_ALLOC;
			cht_pkg::CMD_FREE:       item.op = cht_pkg::OP_FREE;
			cht_pkg::CMD_QUERY:      item.op = cht_pkg::OP_QUERY;
			cht_pkg::CMD_GET_PSTATE: item.op = cht_pkg::OP_GET_PSTATE;
			cht_pkg::CMD_SET_PSTATE: item.op = cht_pkg::OP_SET_PSTATE;
			cht_pkg::CMD_NOTE_HANG:  item.op = cht_pkg::OP_NOTE_HANG;
			default:                 item.op = cht_pkg::OP_BAD;
		endcase
	end

endmodule

// ===== rtl/cht_queue.sv =====
// Two-entry queue of decoded items between the front and back ends.
// Depends on cht_pkg.
module cht_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  cht_pkg::item_t push_item,
	input  logic           pop,
	output cht_pkg::item_t pop_item,
	output logic           empty,
	output logic           full
);

	cht_pkg::item_t entry_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;

	assign empty    = (count_q == 2'd0);
	assign full     = (count_q == 2'd2);
	assign pop_item = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_item;
	end

endmodule

// ===== rtl/cht_back.sv =====
// Back end: holds the live bits and the hang counter memory and carries out items.
// Depends on cht_pkg.
module cht_back #(
	parameter int NUM_CONTEXTS = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_empty,
	input  cht_pkg::item_t                q_item,
	output logic                          q_pop,
	output logic                          done,
	output logic [cht_pkg::STATUS_W-1:0]  status,
	output logic [cht_pkg::HANDLE_W-1:0]  new_handle,
	output logic [cht_pkg::HANGS_W-1:0]   hang_total,
	output logic                          guilty_reset
);

	localparam int SW      = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1;
	localparam int XW      = (SW > cht_pkg::HANDLE_W) ? SW : cht_pkg::HANDLE_W;
	localparam int NW      = XW + 1;
	localparam int NUM_GRP = (NUM_CONTEXTS + cht_pkg::GRP_SIZE - 1) / cht_pkg::GRP_SIZE;
	localparam int GW      = (NUM_GRP > 1) ? $clog2(NUM_GRP) : 1;
	localparam int PADW    = NUM_GRP * cht_pkg::GRP_SIZE;

	cht_pkg::bk_state_t state_q;
	cht_pkg::item_t     cur_q;
	logic [NUM_CONTEXTS-1:0] live_q;
	logic [cht_pkg::HANGS_W-1:0] hangs_mem [NUM_CONTEXTS];
	logic [cht_pkg::HANGS_W-1:0] rd_q;
	logic [NUM_GRP-1:0] grp_free_q;
	logic [cht_pkg::GRP_IDX_W-1:0] grp_loc_q [NUM_GRP];

	logic [PADW-1:0] live_pad;
	logic [NUM_GRP-1:0] grp_free_d;
	logic [cht_pkg::GRP_IDX_W-1:0] grp_loc_d [NUM_GRP];
	logic [SW-1:0] slot;
	logic          hit;
	logic          any_free;
	logic [GW-1:0] g_sel;
	logic [SW-1:0] found;
	logic [NW-1:0] found_handle;

	logic                          mem_we;
	logic [SW-1:0]                 mem_wa;
	logic [cht_pkg::HANGS_W-1:0]   mem_wd;
	logic                          live_we;
	logic [SW-1:0]                 live_wa;
	logic                          live_wd;
	logic [cht_pkg::STATUS_W-1:0]  status_d;
	logic [cht_pkg::HANDLE_W-1:0]  new_handle_d;
	logic [cht_pkg::HANGS_W-1:0]   hang_total_d;
	logic                          guilty_d;

	assign q_pop = (state_q == cht_pkg::BK_IDLE) && !q_empty;
	assign slot  = cur_q.slot[SW-1:0];
	assign hit   = cur_q.in_range && live_q[slot];

	// The first free slot is found in two steps: a registered search within each
	// group of sixteen, then a choice of the lowest group that has a free slot.
	always_comb begin
		live_pad = '1;
		live_pad[NUM_CONTEXTS-1:0] = live_q;
		for (int g = 0; g < NUM_GRP; g++) begin
			grp_free_d[g] = 1'b0;
			grp_loc_d[g]  = '0;
			for (int b = cht_pkg::GRP_SIZE - 1; b >= 0; b--) begin
				if (!live_pad[g * cht_pkg::GRP_SIZE + b]) begin
					grp_free_d[g] = 1'b1;
					grp_loc_d[g]  = cht_pkg::GRP_IDX_W'(b);
				end
			end
		end
	end

	always_comb begin
		any_free = 1'b0;
		g_sel    = '0;
		for (int g = NUM_GRP - 1; g >= 0; g--) begin
			if (grp_free_q[g]) begin
				any_free = 1'b1;
				g_sel    = GW'(g);
			end
		end
		found        = SW'({g_sel, grp_loc_q[g_sel]});
		found_handle = NW'(found) + NW'(1);
	end

	always_comb begin
		mem_we       = 1'b0;
		mem_wa       = slot;
		mem_wd       = '0;
		live_we      = 1'b0;
		live_wa      = slot;
		live_wd      = 1'b0;
		status_d     = cht_pkg::STATUS_INVALID;
		new_handle_d = '0;
		hang_total_d = '0;
		guilty_d     = 1'b0;
		unique case (cur_q.op)
			cht_pkg::OP_ALLOC: begin
				if (any_free) begin
					status_d     = cht_pkg::STATUS_OK;
					new_handle_d = found_handle[cht_pkg::HANDLE_W-1:0];
					mem_we       = 1'b1;
					mem_wa       = found;
					live_we      = 1'b1;
					live_wa      = found;
					live_wd      = 1'b1;
				end else begin
					status_d = cht_pkg::STATUS_FULL;
				end
			end
			cht_pkg::OP_FREE: begin
				if (hit) begin
					status_d = cht_pkg::STATUS_OK;
					mem_we   = 1'b1;
					live_we  = 1'b1;
				end
			end
			cht_pkg::OP_QUERY: begin
				if (hit) begin
					status_d     = cht_pkg::STATUS_OK;
					hang_total_d = rd_q;
					guilty_d     = (rd_q != '0);
				end
			end
			cht_pkg::OP_GET_PSTATE: begin
				if (hit)
					status_d = cht_pkg::STATUS_OK;
			end
			cht_pkg::OP_SET_PSTATE: begin
				status_d = cht_pkg::STATUS_NOPERM;
			end
			cht_pkg::OP_NOTE_HANG: begin
				if (hit) begin
					status_d = cht_pkg::STATUS_OK;
					mem_we   = 1'b1;
					mem_wd   = rd_q + cht_pkg::HANGS_W'(1);
				end
			end
			default: begin
				status_d = cht_pkg::STATUS_INVALID;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cht_pkg::BK_IDLE;
			live_q  <= '0;
			done    <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				cht_pkg::BK_IDLE: begin
					if (!q_empty)
						state_q <= cht_pkg::BK_READ;
				end
				cht_pkg::BK_READ: begin
					state_q <= cht_pkg::BK_EXEC;
				end
				cht_pkg::BK_EXEC: begin
					state_q <= cht_pkg::BK_IDLE;
					done    <= 1'b1;
					if (live_we)
						live_q[live_wa] <= live_wd;
				end
				default: begin
					state_q <= cht_pkg::BK_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop)
			cur_q <= q_item;
		if (state_q == cht_pkg::BK_READ) begin
			rd_q       <= hangs_mem[slot];
			grp_free_q <= grp_free_d;
			grp_loc_q  <= grp_loc_d;
		end
		if (state_q == cht_pkg::BK_EXEC) begin
			if (mem_we)
				hangs_mem[mem_wa] <= mem_wd;
			status       <= status_d;
			new_handle   <= new_handle_d;
			hang_total   <= hang_total_d;
			guilty_reset <= guilty_d;
		end
	end

endmodule

// ===== rtl/context_handle_table.sv =====
// Top level of the context handle table: front end, item queue and back end.
// Depends on cht_pkg, cht_front, cht_queue and cht_back.
//
//   Channel   Handshake        Payload
//   command   start / busy     command, context_handle
//   result    done (strobe)    status, new_handle, hang_total, guilty_reset
//
// An item is accepted when start is high and busy is low; busy is high while
// the two-entry queue is full. The back end carries each item through pop,
// hang memory read with first-free group search and execute, and pops no new
// item until the last one has executed. Reset clears all live bits at once;
// the hang memory needs no clearing as a slot's count is only used while the
// slot is live and is zeroed when it is allocated. Results cannot be stalled.
module context_handle_table #(
	parameter int NUM_CONTEXTS = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [cht_pkg::CMD_W-1:0]     command,
	input  logic [cht_pkg::HANDLE_W-1:0]  context_handle,
	output logic                          done,
	output logic [cht_pkg::STATUS_W-1:0]  status,
	output logic [cht_pkg::HANDLE_W-1:0]  new_handle,
	output logic [cht_pkg::HANGS_W-1:0]   hang_total,
	output logic                          guilty_reset
);

	cht_pkg::item_t front_item;
	cht_pkg::item_t q_item;
	logic           q_empty;
	logic           q_full;
	logic           q_pop;
	logic           accept;

	assign busy   = q_full;
	assign accept = start && !q_full;

	cht_front #(
		.NUM_CONTEXTS(NUM_CONTEXTS)
	) u_front (
		.command       (command),
		.context_handle(context_handle),
		.item          (front_item)
	);

	cht_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (accept),
		.push_item(front_item),
		.pop      (q_pop),
		.pop_item (q_item),
		.empty    (q_empty),
		.full     (q_full)
	);

	cht_back #(
		.NUM_CONTEXTS(NUM_CONTEXTS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_item      (q_item),
		.q_pop       (q_pop),
		.done        (done),
		.status      (status),
		.new_handle  (new_handle),
		.hang_total  (hang_total),
		.guilty_reset(guilty_reset)
	);

endmodule

// ===== rtl/cht_checker.sv =====
// Port-level checks on the context handle table, bound to its top level.
// Depends on cht_pkg and context_handle_table.
module cht_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic [cht_pkg::CMD_W-1:0]     command,
	input logic [cht_pkg::HANDLE_W-1:0]  context_handle,
	input logic                          done,
	input logic [cht_pkg::STATUS_W-1:0]  status,
	input logic [cht_pkg::HANDLE_W-1:0]  new_handle,
	input logic [cht_pkg::HANGS_W-1:0]   hang_total,
	input logic                          guilty_reset
);

	a_item_known: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> !$isunknown({command, context_handle}))
		else $error("accepted item carries unknown bits");

	a_fail_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status != cht_pkg::STATUS_OK) |->
			(new_handle == '0) && (hang_total == '0) && !guilty_reset)
		else $error("failed item carries nonzero result fields");

	a_guilty_matches_count: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == cht_pkg::STATUS_OK) |->
			(guilty_reset == (hang_total != '0)))
		else $error("guilty flag disagrees with hang count");

	a_result_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("results closer than the back end allows");

	a_no_result_after_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!busy && !$past(start) && !$past(start, 2) && !$past(start, 3) &&
			!$past(busy) && !$past(busy, 2) && !$past(busy, 3) &&
			!$past(done) && !$past(done, 2) && !$past(done, 3) &&
			!$past(done, 4) && !$past(start, 4) && !$past(busy, 4) |-> !done)
		else $error("result without an item");

endmodule

bind context_handle_table cht_checker u_cht_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.command       (command),
	.context_handle(context_handle),
	.done          (done),
	.status        (status),
	.new_handle    (new_handle),
	.hang_total    (hang_total),
	.guilty_reset  (guilty_reset)
);
